// ===== rtl/pid_drive_to_distance_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the drive-to-distance unit
// ---------------------------------------------------------------------------
`ifndef PID_DRIVE_TO_DISTANCE_UNIT_MACROS_SVH
`define PID_DRIVE_TO_DISTANCE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define PDD_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("drive unit check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define PDD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("drive unit check failed");

`endif

// ===== rtl/pdd_pkg.sv =====
// ---------------------------------------------------------------------------
// pdd_pkg
// Shared widths, codes, stage payloads and the minimum power function.
// ---------------------------------------------------------------------------
package pdd_pkg;

  localparam int TARGET_W = 15;
  localparam int GAIN_W   = 16;
  localparam int COUNT_W  = 17;
  localparam int POWER_W  = 7;
  localparam int SUM_W    = 39;   // integral never goes negative
  localparam int E2_W     = 18;   // error in half counts, non-negative on the run path
  localparam int DE_W     = 19;   // signed error difference
  localparam int SETTLE_W = 3;
  localparam int ACC_W    = 58;
  localparam int SUM_LO_W = 20;
  localparam int SUM_HI_W = SUM_W - SUM_LO_W;

  localparam int SETTLE_TICKS = 6;
  localparam int SETTLE_BAND  = 15;
  localparam int SETTLE_MAX   = 7;
  localparam int POWER_MAX    = 127;
  localparam int MIN_BASE     = 65;
  localparam int MIN_FLOOR    = 20;

  localparam logic [TARGET_W-1:0] TARGET_RST = 15'd600;
  localparam logic [GAIN_W-1:0]   KP_RST     = 16'd87;
  localparam logic [GAIN_W-1:0]   KI_RST     = 16'd67;
  localparam logic [GAIN_W-1:0]   KD_RST     = 16'd220;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_PROP   = 2'd1,
    REG_INTEG  = 2'd2,
    REG_DERIV  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [GAIN_W-1:0]   kp;
    logic [GAIN_W-1:0]   ki;
    logic [GAIN_W-1:0]   kd;
  } cfg_t;

  // Payload handed from the error stage to the power stage
  typedef struct packed {
    logic                   zero_pwr;  // start, exit or finished: power is forced to 0
    logic                   done;
    logic [E2_W-1:0]        e2;
    logic [SUM_W-1:0]       sum;
    logic signed [DE_W-1:0] de2;
  } err_t;

  // Minimum power: 65 - ceil(target/2), never below 20
  function automatic logic [POWER_W-1:0] min_power(input logic [TARGET_W-1:0] target);
    logic [TARGET_W:0]   tp1;
    logic [TARGET_W-1:0] half;
    tp1  = {1'b0, target} + (TARGET_W+1)'(1);
    half = tp1[TARGET_W:1];
    if (half >= TARGET_W'(MIN_BASE - MIN_FLOOR)) begin
      min_power = POWER_W'(MIN_FLOOR);
    end else begin
      min_power = POWER_W'(MIN_BASE) - half[POWER_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/pdd_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// pdd_cfg_regs
// APB register file for target distance and the three loop gains.
// ---------------------------------------------------------------------------
module pdd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [3:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready,
  output pdd_pkg::cfg_t cfg
);

  pdd_pkg::cfg_t     cfg_r;
  pdd_pkg::cfg_t     cfg_nxt;
  pdd_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx        = pdd_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        pdd_pkg::REG_TARGET: cfg_nxt.target = cfg_pwdata[pdd_pkg::TARGET_W-1:0];
        pdd_pkg::REG_PROP:   cfg_nxt.kp     = cfg_pwdata[pdd_pkg::GAIN_W-1:0];
        pdd_pkg::REG_INTEG:  cfg_nxt.ki     = cfg_pwdata[pdd_pkg::GAIN_W-1:0];
        pdd_pkg::REG_DERIV:  cfg_nxt.kd     = cfg_pwdata[pdd_pkg::GAIN_W-1:0];
        default:             cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= pdd_pkg::TARGET_RST;
      cfg_r.kp     <= pdd_pkg::KP_RST;
      cfg_r.ki     <= pdd_pkg::KI_RST;
      cfg_r.kd     <= pdd_pkg::KD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      pdd_pkg::REG_TARGET: cfg_prdata = 32'(cfg_r.target);
      pdd_pkg::REG_PROP:   cfg_prdata = 32'(cfg_r.kp);
      pdd_pkg::REG_INTEG:  cfg_prdata = 32'(cfg_r.ki);
      pdd_pkg::REG_DERIV:  cfg_prdata = 32'(cfg_r.kd);
      default:             cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/pdd_error_stage.sv =====
// ---------------------------------------------------------------------------
// pdd_error_stage
// Input register, error computation and the controller state update.
// ---------------------------------------------------------------------------
module pdd_error_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [pdd_pkg::TARGET_W-1:0]        target,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic signed [pdd_pkg::COUNT_W-1:0]  in_right,
  input  logic signed [pdd_pkg::COUNT_W-1:0]  in_left,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pdd_pkg::err_t                       out_pay
);

  localparam int SUMC_W = pdd_pkg::COUNT_W + 1;
  localparam int E2F_W  = pdd_pkg::E2_W + 2;

  // Input register
  logic                               v0_r;
  logic                               cmd0_r;
  logic signed [pdd_pkg::COUNT_W-1:0] right0_r;
  logic signed [pdd_pkg::COUNT_W-1:0] left0_r;

  // Controller state
  logic [pdd_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [pdd_pkg::E2_W-1:0]     last_r, last_nxt;
  logic [pdd_pkg::SETTLE_W-1:0] settle_r, settle_nxt;
  logic                         fin_r, fin_nxt;

  // Stage register toward the power stage
  logic          v1_r;
  pdd_pkg::err_t pay1_r;
  pdd_pkg::err_t pay;

  logic                     rdy1;
  logic                     fire1;
  logic signed [SUMC_W-1:0] cnt_sum;
  logic signed [E2F_W-1:0]  e2_full;
  logic                     e2_neg;
  logic [pdd_pkg::E2_W-1:0] e2;
  logic                     in_band;
  logic [pdd_pkg::SUM_W:0]  sum_add;

  assign rdy1      = !v1_r || out_ready;
  assign in_ready  = !v0_r || rdy1;
  assign fire1     = v0_r && rdy1;
  assign out_valid = v1_r;
  assign out_pay   = pay1_r;

  // Error in half counts and its derived terms
  always_comb begin
    cnt_sum = SUMC_W'(right0_r) + SUMC_W'(left0_r);
    e2_full = $signed({{(E2F_W-pdd_pkg::TARGET_W-1){1'b0}}, target, 1'b0})
              - E2F_W'(cnt_sum);
    e2_neg  = e2_full[E2F_W-1];
    e2      = e2_full[pdd_pkg::E2_W-1:0];
    in_band = e2[pdd_pkg::E2_W-1:1] < (pdd_pkg::E2_W-1)'(pdd_pkg::SETTLE_BAND);
    sum_add = {1'b0, sum_r} + (pdd_pkg::SUM_W+1)'(e2);
  end

  // Step the controller
  always_comb begin
    sum_nxt      = sum_r;
    last_nxt     = last_r;
    settle_nxt   = settle_r;
    fin_nxt      = fin_r;
    pay          = '0;
    pay.zero_pwr = 1'b1;
    if (cmd0_r == pdd_pkg::CMD_START) begin
      sum_nxt    = '0;
      last_nxt   = '0;
      settle_nxt = '0;
      fin_nxt    = 1'b0;
    end else if (fin_r) begin
      pay.done = 1'b1;
    end else if (settle_r >= pdd_pkg::SETTLE_W'(pdd_pkg::SETTLE_TICKS) || e2_neg) begin
      fin_nxt  = 1'b1;
      pay.done = 1'b1;
    end else begin
      if (in_band) begin
        if (settle_r < pdd_pkg::SETTLE_W'(pdd_pkg::SETTLE_MAX)) begin
          settle_nxt = settle_r + pdd_pkg::SETTLE_W'(1);
        end
      end else begin
        settle_nxt = '0;
      end
      // integral only grows here, so saturate at the top alone
      sum_nxt      = sum_add[pdd_pkg::SUM_W] ? '1 : sum_add[pdd_pkg::SUM_W-1:0];
      last_nxt     = e2;
      pay.zero_pwr = 1'b0;
      pay.e2       = e2;
      pay.sum      = sum_nxt;
      pay.de2      = $signed({1'b0, e2}) - $signed({1'b0, last_r});
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      sum_r    <= '0;
      last_r   <= '0;
      settle_r <= '0;
      fin_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        v0_r <= in_valid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (fire1) begin
        sum_r    <= sum_nxt;
        last_r   <= last_nxt;
        settle_r <= settle_nxt;
        fin_r    <= fin_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd0_r   <= in_cmd;
      right0_r <= in_right;
      left0_r  <= in_left;
    end
    if (fire1) begin
      pay1_r <= pay;
    end
  end

endmodule

// ===== rtl/pdd_power_stage.sv =====
// ---------------------------------------------------------------------------
// pdd_power_stage
// Gain products, accumulation, scaling and clamping of the drive power.
// ---------------------------------------------------------------------------
module pdd_power_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pdd_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pdd_pkg::err_t                in_pay,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pdd_pkg::POWER_W-1:0]  out_power,
  output logic                         out_done
);

  localparam int PP_W  = pdd_pkg::GAIN_W + pdd_pkg::E2_W;
  localparam int PD_W  = pdd_pkg::GAIN_W + 1 + pdd_pkg::DE_W;
  localparam int PL_W  = pdd_pkg::GAIN_W + pdd_pkg::SUM_LO_W;
  localparam int PH_W  = pdd_pkg::GAIN_W + pdd_pkg::SUM_HI_W;
  localparam int Q_W   = pdd_pkg::ACC_W - 10;

  // Product stage
  logic                   v2_r;
  logic                   zero2_r, done2_r;
  logic [PP_W-1:0]        prod_p_r;
  logic signed [PD_W-1:0] prod_d_r;
  logic [PL_W-1:0]        prod_lo_r;
  logic [PH_W-1:0]        prod_hi_r;

  // Accumulate stage
  logic                        v3_r;
  logic                        zero3_r, done3_r;
  logic [pdd_pkg::ACC_W-1:0]   acc_r, acc_nxt;

  // Output register
  logic                        vo_r;
  logic [pdd_pkg::POWER_W-1:0] pwr_r, pwr_nxt;
  logic                        done_r;

  logic                        rdy2, rdy3, rdyo;
  logic [pdd_pkg::POWER_W-1:0] minp;
  logic [Q_W-1:0]              q;

  assign rdyo      = !vo_r || out_ready;
  assign rdy3      = !v3_r || rdyo;
  assign rdy2      = !v2_r || rdy3;
  assign in_ready  = rdy2;
  assign out_valid = vo_r;
  assign out_power = pwr_r;
  assign out_done  = done_r;

  // Sum the four products; the high integral product sits 20 bits up
  assign acc_nxt = pdd_pkg::ACC_W'(prod_p_r)
                 + {{(pdd_pkg::ACC_W-PD_W){prod_d_r[PD_W-1]}}, prod_d_r}
                 + pdd_pkg::ACC_W'(prod_lo_r)
                 + {{(pdd_pkg::ACC_W-PH_W-pdd_pkg::SUM_LO_W){1'b0}}, prod_hi_r,
                    {pdd_pkg::SUM_LO_W{1'b0}}};

  // Scale by 1/512, then floor and saturate
  always_comb begin
    minp = pdd_pkg::min_power(cfg.target);
    q    = acc_r[pdd_pkg::ACC_W-2:9];
    if (zero3_r) begin
      pwr_nxt = '0;
    end else if (acc_r[pdd_pkg::ACC_W-1]) begin
      pwr_nxt = minp;
    end else if (|q[Q_W-1:pdd_pkg::POWER_W]) begin
      pwr_nxt = pdd_pkg::POWER_W'(pdd_pkg::POWER_MAX);
    end else if (q[pdd_pkg::POWER_W-1:0] < minp) begin
      pwr_nxt = minp;
    end else begin
      pwr_nxt = q[pdd_pkg::POWER_W-1:0];
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= in_valid;
      if (rdy3) v3_r <= v2_r;
      if (rdyo) vo_r <= v3_r;
    end
  end

  // Payload through the stages
  always_ff @(posedge clk) begin
    if (in_valid && rdy2) begin
      zero2_r   <= in_pay.zero_pwr;
      done2_r   <= in_pay.done;
      prod_p_r  <= cfg.kp * in_pay.e2;
      prod_d_r  <= $signed({1'b0, cfg.kd}) * in_pay.de2;
      prod_lo_r <= cfg.ki * in_pay.sum[pdd_pkg::SUM_LO_W-1:0];
      prod_hi_r <= cfg.ki * in_pay.sum[pdd_pkg::SUM_W-1:pdd_pkg::SUM_LO_W];
    end
    if (v2_r && rdy3) begin
      zero3_r <= zero2_r;
      done3_r <= done2_r;
      acc_r   <= acc_nxt;
    end
    if (v3_r && rdyo) begin
      pwr_r  <= pwr_nxt;
      done_r <= done3_r;
    end
  end

endmodule

// ===== rtl/pid_drive_to_distance_unit.sv =====
// ---------------------------------------------------------------------------
// pid_drive_to_distance_unit
// Drive-to-distance PID controller with settle and overshoot detection.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake           | contents
//  ---------+-----------+---------------------+------------------------------
//  in_      | slave     | in_tvalid/in_tready | tuser cmd, tdata counts
//  out_     | master    | out_tvalid/tready   | tuser done, tdata power
//  cfg_     | APB slave | psel/penable        | target and gains, pready high
//
//  One item per cycle sustained while out_ tready stays high; the input register
//  loads at the transfer, then the error/state stage, products, sum and output
//  registers follow in turn.
//  The integral, last error and settle count update in the error stage, so
//  consecutive ticks follow back to back.
//  Reset clears the pipeline valids and the move state; registers take defaults.
//  A stall on out_ tready backs up stage by stage; empty stages keep filling.
// ---------------------------------------------------------------------------
module pid_drive_to_distance_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [16:0] right_count, [33:17] left_count
  input  logic        in_tuser,    // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [6:0] drive_power
  output logic        out_tuser,   // [0] done_res
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  pdd_pkg::cfg_t               cfg;
  logic                        err_valid, err_ready;
  pdd_pkg::err_t               err_pay;
  logic [pdd_pkg::POWER_W-1:0] power;

  pdd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pdd_error_stage u_err (
    .clk       (clk),
    .rst_n     (rst_n),
    .target    (cfg.target),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_right  ($signed(in_tdata[16:0])),
    .in_left   ($signed(in_tdata[33:17])),
    .out_valid (err_valid),
    .out_ready (err_ready),
    .out_pay   (err_pay)
  );

  pdd_power_stage u_pwr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_pay    (err_pay),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_power (power),
    .out_done  (out_tuser)
  );

  assign out_tdata = {1'b0, power};

endmodule

// ===== rtl/pdd_checker.sv =====
// ---------------------------------------------------------------------------
// pdd_checker
// Port-level checks on the drive unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "pid_drive_to_distance_unit_macros.svh"

module pdd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser
);

  // A stalled result holds until taken
  `PDD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // A finished move always drives zero power
  `PDD_ASSERT_NOW(a_done_zero, out_tvalid && out_tuser, out_tdata == 8'd0)

  // Power is either off or at least the floor minimum
  `PDD_ASSERT_NOW(a_power_floor, out_tvalid, out_tdata == 8'd0 || out_tdata >= 8'd20)

  // No result straight out of reset
  `PDD_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_tvalid)

endmodule

bind pid_drive_to_distance_unit pdd_checker u_pdd_checker (.*);

// ===== bench/pid_drive_to_distance_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pid_drive_to_distance_checker
// Watches the input, result and register channels of the drive unit, keeps
// its own copy of the controller state and gains, works out the power and
// done flag for every input transfer and compares each result transfer
// against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module pid_drive_to_distance_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [39:0]       in_tdata,    // [16:0] right_count, [33:17] left_count
  input  logic              in_tuser,    // [0] cmd
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [7:0]        out_tdata,   // [6:0] drive_power
  input  logic              out_tuser,   // [0] done_res
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic              cfg_pready,
  output int unsigned       failures,
  output int unsigned       outstanding
);
  import pdd_pkg::*;

  localparam longint SUM_CEIL = (64'sd1 <<< SUM_W) - 1;

  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic               done;
  } drive_result_t;

  // Shadow of the gain and distance registers
  logic [TARGET_W-1:0] target_q = TARGET_RST;
  logic [GAIN_W-1:0]   kp_q     = KP_RST;
  logic [GAIN_W-1:0]   ki_q     = KI_RST;
  logic [GAIN_W-1:0]   kd_q     = KD_RST;

  // Move state, error terms in half counts
  longint integral_q = 0;
  longint prev_err_q = 0;
  int     settle_q   = 0;
  logic   done_q     = 1'b0;

  drive_result_t power_queue[$];
  int unsigned   fail_count = 0;

  assign failures = fail_count;

  function automatic void clear_move_state();
    integral_q = 0;
    prev_err_q = 0;
    settle_q   = 0;
    done_q     = 1'b0;
  endfunction

  // Advance the move state by one input item and return the expected result
  function automatic drive_result_t next_drive_result(input logic cmd,
                                                      input logic signed [COUNT_W-1:0] rc,
                                                      input logic signed [COUNT_W-1:0] lc);
    drive_result_t res;
    longint err, derr, acc, pwr, floor_pwr;
    res.power = '0;
    res.done  = 1'b0;
    if (cmd == CMD_START) begin
      clear_move_state();
      return res;
    end
    if (done_q) begin
      res.done = 1'b1;
      return res;
    end
    err = 2 * longint'(target_q) - (longint'(rc) + longint'(lc));
    // settled long enough, or driven past the target
    if (settle_q >= SETTLE_TICKS || err < 0) begin
      done_q   = 1'b1;
      res.done = 1'b1;
      return res;
    end
    if ((err >>> 1) < SETTLE_BAND) begin
      if (settle_q < SETTLE_MAX) settle_q++;
    end else begin
      settle_q = 0;
    end
    if (integral_q > SUM_CEIL - err) integral_q = SUM_CEIL;
    else integral_q += err;
    derr       = err - prev_err_q;
    prev_err_q = err;
    acc = longint'(kp_q) * err + longint'(ki_q) * integral_q + longint'(kd_q) * derr;
    pwr = acc / 512;
    floor_pwr = MIN_BASE - (longint'(target_q) + 1) / 2;
    if (floor_pwr < MIN_FLOOR) floor_pwr = MIN_FLOOR;
    if (pwr < floor_pwr) pwr = floor_pwr;
    if (pwr > POWER_MAX) pwr = POWER_MAX;
    res.power = POWER_W'(pwr);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    drive_result_t got, want;
    if (!rst_n) begin
      target_q = TARGET_RST;
      kp_q     = KP_RST;
      ki_q     = KI_RST;
      kd_q     = KD_RST;
      clear_move_state();
      power_queue.delete();
      outstanding <= 0;
    end else begin
      // track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_TARGET: target_q = cfg_pwdata[TARGET_W-1:0];
          REG_PROP:   kp_q     = cfg_pwdata[GAIN_W-1:0];
          REG_INTEG:  ki_q     = cfg_pwdata[GAIN_W-1:0];
          REG_DERIV:  kd_q     = cfg_pwdata[GAIN_W-1:0];
          default:    ;
        endcase
      end
      // predict on every input transfer
      if (in_tvalid && in_tready) begin
        power_queue.push_back(next_drive_result(in_tuser, in_tdata[16:0], in_tdata[33:17]));
      end
      // compare every result transfer with the oldest prediction
      if (out_tvalid && out_tready) begin
        got.power = out_tdata[POWER_W-1:0];
        got.done  = out_tuser;
        if (power_queue.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual power %0d done %0b",
                   $time, got.power, got.done);
          fail_count++;
        end else begin
          want = power_queue.pop_front();
          if (got.power !== want.power) begin
            $display("%0t: drive_power mismatch: expected %0d, actual %0d",
                     $time, want.power, got.power);
            fail_count++;
          end
          if (got.done !== want.done) begin
            $display("%0t: done_res mismatch: expected %0b, actual %0b",
                     $time, want.done, got.done);
            fail_count++;
          end
        end
      end
      outstanding <= power_queue.size();
    end
  end

endmodule

// ===== bench/tb_pid_drive_to_distance_unit.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_pid_drive_to_distance_unit
// Drives the drive unit with a short directed sequence and then with random
// moves (start, approach, settle or overshoot, ticks after finish) mixed with
// noise items, across several gain and distance settings. Both channels idle
// at random; the result side holds off for long stretches twice so the
// pipeline backs up. The checker module predicts and compares.
// ---------------------------------------------------------------------------
module tb_pid_drive_to_distance_unit;
  import pdd_pkg::*;

  localparam int     CLK_HALF       = 2;
  localparam int     ITEM_GOAL      = 1950;
  localparam int     PHASE_ITEMS    = 240;
  localparam int     DRAIN_CYCLES   = 16;
  localparam int     SQUEEZE_CYCLES = 400;
  localparam longint CYCLE_LIMIT    = 800000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata    = '0;     // [16:0] right_count, [33:17] left_count
  logic        in_tuser    = 1'b0;   // [0] cmd
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;            // [6:0] drive_power
  logic        out_tuser;            // [0] done_res
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int unsigned failures;
  int unsigned outstanding;

  int     items_sent   = 0;
  int     cur_target   = TARGET_RST;
  bit     tx_steady    = 1'b0;
  bit     rx_steady    = 1'b0;
  int     rx_stall     = 0;
  int     rx_taken     = 0;
  int     rx_draw;
  int     next_squeeze = 300;
  longint cycle_count  = 0;
  int     phase_no;
  int     phase_end;

  pid_drive_to_distance_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pid_drive_to_distance_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int draw_gain();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 600);
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input logic cmd, input logic [COUNT_W-1:0] rc,
                           input logic [COUNT_W-1:0] lc);
    int gap;
    if ($urandom_range(0, 59) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, lc, rc};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Tick whose error is exactly err_half half counts; split the wheel sum
  task automatic send_tick(input int err_half);
    int total, lo, hi, rc;
    total = 2 * cur_target - err_half;
    lo = (total - 65535 > -65536) ? total - 65535 : -65536;
    hi = (total + 65536 < 65535) ? total + 65536 : 65535;
    if ($urandom_range(0, 7) == 0) begin
      rc = lo + int'($urandom_range(hi - lo, 0));
    end else begin
      rc = total / 2 + int'($urandom_range(0, 16)) - 8;
      if (rc < lo) rc = lo;
      if (rc > hi) rc = hi;
    end
    send_item(CMD_TICK, COUNT_W'(rc), COUNT_W'(total - rc));
  endtask

  task automatic run_directed();
    send_item(CMD_TICK, '0, '0);                  // tick before any start
    send_item(CMD_TICK, 17'h10000, 17'h10000);    // most negative counts
    send_item(CMD_TICK, 17'h0FFFF, 17'h10000);
    send_item(CMD_TICK, 17'h0FFFF, 17'h0FFFF);    // far past target, exits
    send_item(CMD_TICK, '0, '0);                  // tick after finish
    send_item(CMD_START, 17'h0FFFF, 17'h1FFFF);
    send_tick(0);                                 // zero error still runs
    send_tick(29);                                // top of the settle band
    send_tick(30);                                // just outside, clears count
    repeat (6) send_tick($urandom_range(0, 29));
    send_tick(12);                                // settled, exits
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_START, '0, '0);
    send_tick(-1);                                // smallest overshoot
    send_item(CMD_START, '0, '0);
  endtask

  // Start, approach the target, then settle, overshoot or abandon
  task automatic drive_move();
    int err_half, step_cap, ending;
    send_item(CMD_START, COUNT_W'($urandom), COUNT_W'($urandom));
    err_half = 2 * cur_target;
    step_cap = (2 * cur_target) / int'($urandom_range(4, 12)) + 2;
    while (err_half >= 40) begin
      send_tick(err_half);
      err_half -= $urandom_range(1, step_cap);
    end
    ending = $urandom_range(0, 9);
    if (ending < 6) begin
      repeat ($urandom_range(5, 9)) begin
        if ($urandom_range(0, 11) == 0) send_tick($urandom_range(30, 80));
        else send_tick($urandom_range(0, 29));
      end
    end else if (ending < 9) begin
      send_tick(-int'($urandom_range(1, 400)));
    end
    repeat ($urandom_range(0, 2)) send_tick($urandom_range(0, 2 * cur_target + 100));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      send_item(1'($urandom_range(0, 1)), COUNT_W'($urandom), COUNT_W'($urandom));
    end
  endtask

  // One register write: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // Drain the unit, then load a new distance and gain set
  task automatic reconfigure(input int phase);
    int tgt, kp, ki, kd;
    case (phase)
      1: begin
        tgt = 0; kp = 0; ki = 0; kd = 0;
      end
      2: begin
        tgt = 32767; kp = 65535; ki = 65535; kd = 65535;
      end
      default: begin
        tgt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 1500);
        kp  = draw_gain();
        ki  = draw_gain();
        kd  = draw_gain();
      end
    endcase
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_TARGET, {17'($urandom), 15'(tgt)});
    write_reg(REG_PROP,   {16'($urandom), 16'(kp)});
    write_reg(REG_INTEG,  {16'($urandom), 16'(ki)});
    write_reg(REG_DERIV,  {16'($urandom), 16'(kd)});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cur_target = tgt;
  endtask

  // Result side: random stalls, steady stretches and two long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      rx_stall     <= 0;
      rx_taken     <= 0;
      next_squeeze <= 300;
    end else begin
      if (out_tvalid && out_tready) rx_taken <= rx_taken + 1;
      if ($urandom_range(0, 199) == 0) rx_steady <= !rx_steady;
      if (rx_stall != 0) begin
        rx_stall <= rx_stall - 1;
      end else if (rx_taken >= next_squeeze) begin
        out_tready   <= 1'b0;
        rx_stall     <= SQUEEZE_CYCLES;
        next_squeeze <= next_squeeze + 1040;
      end else if (rx_steady) begin
        out_tready <= 1'b1;
      end else begin
        rx_draw = pick_gap();
        out_tready <= (rx_draw == 0);
        if (rx_draw > 0) rx_stall <= rx_draw - 1;
      end
    end
  end

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    phase_no = 0;
    while (items_sent < ITEM_GOAL) begin
      if (phase_no > 0) reconfigure(phase_no);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < ITEM_GOAL) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else drive_move();
      end
      phase_no++;
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
